>>> rtl/skvt_pkg.sv
package skvt_pkg;

    localparam int OP_W  = 3;
    localparam int KEY_W = 64;
    localparam int VAL_W = 32;

    localparam logic [OP_W-1:0] OP_FIND   = 3'd0;
    localparam logic [OP_W-1:0] OP_GET    = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [VAL_W-1:0] t_val;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic ers;
        logic wr;
        t_key key;
        t_val value;
    } t_bcast;

endpackage

>>> rtl/skvt_cell.sv
module skvt_cell (
    input  logic             i_clk,
    input  skvt_pkg::t_bcast i_bc,
    input  logic             i_occupied,
    input  logic             i_left_lt,
    input  skvt_pkg::t_key   i_left_key,
    input  skvt_pkg::t_val   i_left_val,
    input  skvt_pkg::t_key   i_right_key,
    input  skvt_pkg::t_val   i_right_val,
    output logic             o_lt,
    output logic             o_eq,
    output skvt_pkg::t_key   o_key,
    output skvt_pkg::t_val   o_val
);

    logic           r_lt;
    logic           r_eq;
    skvt_pkg::t_key r_key;
    skvt_pkg::t_val r_val;

    always_ff @(posedge i_clk) begin
        if (i_bc.cmp) begin
            r_lt <= i_occupied && (r_key < i_bc.key);
            r_eq <= i_occupied && (r_key == i_bc.key);
        end
        priority if (i_bc.ins && !r_lt) begin
            if (i_left_lt) begin
                r_key <= i_bc.key;
                r_val <= i_bc.value;
            end else begin
                r_key <= i_left_key;
                r_val <= i_left_val;
            end
        end else if (i_bc.ers && !r_lt) begin
            r_key <= i_right_key;
            r_val <= i_right_val;
        end else if (i_bc.wr && r_eq) begin
            r_val <= i_bc.value;
        end else begin
            // hold
            r_key <= r_key;
            r_val <= r_val;
        end
    end

    assign o_lt  = r_lt;
    assign o_eq  = r_eq;
    assign o_key = r_key;
    assign o_val = r_val;

endmodule

>>> rtl/sorted_key_value_table_top.sv
// Sorted key/value table held in a row of cells, lowest key in cell 0.
// Command channel: an operation with key and value is taken at the rising
// edge where start is high and busy is low. Operations are find, get,
// insert, erase and clear; unused codes act as find. Only the low
// 8*KEY_BYTES bits of the key take part.
// Each cell compares its key with the command key in the compare state; in
// the next cycle each cell shifts left or right, loads the new entry, takes
// a new value for an equal key or holds; insert and erase shift at once.
// Result channel: one beat per command, shown for one cycle with o_done.
// A command passes the compare state, then the update state; o_done is
// registered and rises at the edge that ends the update state. busy is
// high for the compare cycle only, so a new command can be taken during the
// update cycle of the one before, paced by the cells' compare-then-shift.
// The receiver cannot stall: each beat is shown exactly once and must be
// taken in that cycle.
// Reset (synchronous, active low) empties the table and drops any command
// in flight; no beat is shown for it.
// A get or insert of a new key on a full table leaves it unchanged and
// returns o_status high.
module sorted_key_value_table_top #(
    parameter int DEPTH     = 64,
    parameter int KEY_BYTES = 8,
    localparam int CW       = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [skvt_pkg::OP_W-1:0]   i_operation,
    input  logic [skvt_pkg::KEY_W-1:0]  i_key,
    input  logic [skvt_pkg::VAL_W-1:0]  i_value,
    output logic                        o_done,
    output logic                        o_found,
    output logic [skvt_pkg::VAL_W-1:0]  o_entry_value,
    output logic                        o_status,
    output logic [CW-1:0]               o_entry_count
);

    localparam skvt_pkg::t_key KeyMask =
        {skvt_pkg::KEY_W{1'b1}} >> (skvt_pkg::KEY_W - 8 * KEY_BYTES);

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} t_state;

    t_state                       r_state;
    logic [skvt_pkg::OP_W-1:0]    r_op;
    skvt_pkg::t_key               r_key;
    skvt_pkg::t_val               r_value;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic                         r_done;
    logic                         r_found;
    skvt_pkg::t_val               r_out_val;
    logic                         r_status;
    logic [CW-1:0]                r_out_count;

    logic                         accept;
    logic                         upd;
    logic                         hit;
    logic                         full;
    logic                         is_store;
    logic                         do_ins;
    logic                         do_ers;
    skvt_pkg::t_val               hit_val;
    skvt_pkg::t_val               n_out_val;
    skvt_pkg::t_bcast             bc;

    logic [DEPTH-1:0]             lt;
    logic [DEPTH-1:0]             eq;
    skvt_pkg::t_key               cell_key [DEPTH];
    skvt_pkg::t_val               cell_val [DEPTH];

    assign busy   = (r_state == S_CMP);
    assign accept = start && !busy;
    assign upd    = (r_state == S_UPD);

    always_comb begin
        hit_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_val = hit_val | (cell_val[i] & {skvt_pkg::VAL_W{eq[i]}});
        end
    end

    assign hit      = |eq;
    assign full     = (r_count == CW'(DEPTH));
    assign is_store = (r_op == skvt_pkg::OP_GET) || (r_op == skvt_pkg::OP_INSERT);
    assign do_ins   = upd && is_store && !hit && !full;
    assign do_ers   = upd && (r_op == skvt_pkg::OP_ERASE) && hit;

    always_comb begin
        bc.cmp   = (r_state == S_CMP);
        bc.ins   = do_ins;
        bc.ers   = do_ers;
        bc.wr    = upd && (r_op == skvt_pkg::OP_INSERT) && hit;
        bc.key   = r_key;
        bc.value = (r_op == skvt_pkg::OP_INSERT) ? r_value : '0;
    end

    always_comb begin
        n_count   = r_count;
        n_out_val = '0;
        unique case (r_op)
            skvt_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            skvt_pkg::OP_GET, skvt_pkg::OP_INSERT: begin
                if (hit) begin
                    n_out_val = (r_op == skvt_pkg::OP_INSERT) ? r_value : hit_val;
                end else if (!full) begin
                    n_count   = r_count + CW'(1);
                    n_out_val = bc.value;
                end
            end
            skvt_pkg::OP_ERASE: begin
                if (hit) begin
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                if (hit) begin
                    n_out_val = hit_val;
                end
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        skvt_cell u_cell (
            .i_clk       (i_clk),
            .i_bc        (bc),
            .i_occupied  (CW'(g) < r_count),
            .i_left_lt   ((g == 0) ? 1'b1 : lt[(g == 0) ? 0 : g - 1]),
            .i_left_key  (cell_key[(g == 0) ? 0 : g - 1]),
            .i_left_val  (cell_val[(g == 0) ? 0 : g - 1]),
            .i_right_key (cell_key[(g == DEPTH - 1) ? g : g + 1]),
            .i_right_val (cell_val[(g == DEPTH - 1) ? g : g + 1]),
            .o_lt        (lt[g]),
            .o_eq        (eq[g]),
            .o_key       (cell_key[g]),
            .o_val       (cell_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= upd;
            if (upd) begin
                r_count     <= n_count;
                r_found     <= hit && (r_op != skvt_pkg::OP_CLEAR);
                r_out_val   <= n_out_val;
                r_status    <= is_store && !hit && full;
                r_out_count <= n_count;
            end
            if (accept) begin
                r_state <= S_CMP;
                r_op    <= i_operation;
                r_key   <= i_key & KeyMask;
                r_value <= i_value;
            end else if (r_state == S_CMP) begin
                r_state <= S_UPD;
            end else begin
                r_state <= S_IDLE;
            end
        end
    end

    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_entry_value = r_out_val;
    assign o_status      = r_status;
    assign o_entry_count = r_out_count;

endmodule

>>> rtl/skvt_check.sv
module skvt_check #(
    parameter int DEPTH = 64,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_done,
    input logic                       o_found,
    input logic [skvt_pkg::VAL_W-1:0] o_entry_value,
    input logic                       o_status,
    input logic [CW-1:0]              o_entry_count
);

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than the compare cycle");

    a_beat_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("no result beat three cycles after accept");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (!o_found && (o_entry_value == '0)
            && (o_entry_count == CW'(DEPTH))))
        else $error("drop flagged on a table that is not full");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_entry_count <= CW'(DEPTH)))
        else $error("entry count beyond depth");

endmodule

bind sorted_key_value_table_top skvt_check #(.DEPTH(DEPTH)) u_skvt_check (.*);

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH     = 64;
    localparam int KEY_BYTES = 8;
    localparam int CW        = $clog2(DEPTH + 1);

    typedef logic [skvt_pkg::OP_W-1:0] t_op;

    localparam skvt_pkg::t_key KEY_MASK =
        {skvt_pkg::KEY_W{1'b1}} >> (skvt_pkg::KEY_W - 8 * KEY_BYTES);
    localparam t_op OP_UNUSED_LO  = 3'd5;
    localparam t_op OP_UNUSED_MID = 3'd6;
    localparam t_op OP_UNUSED_HI  = 3'd7;

    typedef struct packed {
        logic           found;
        skvt_pkg::t_val value;
        logic           status;
        logic [CW-1:0]  count;
    } t_table_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_op               i_operation = skvt_pkg::OP_FIND;
    skvt_pkg::t_key    i_key = '0;
    skvt_pkg::t_val    i_value = '0;
    logic              o_done;
    logic              o_found;
    skvt_pkg::t_val    o_entry_value;
    logic              o_status;
    logic [CW-1:0]     o_entry_count;

    skvt_pkg::t_key    tbl_key [DEPTH];
    skvt_pkg::t_val    tbl_val [DEPTH];
    int                tbl_count = 0;
    t_table_reply      reply_q [$];
    int                errors = 0;
    int                burst_left = 0;
    bit                idle_on = 1'b1;

    sorted_key_value_table_top #(
        .DEPTH     (DEPTH),
        .KEY_BYTES (KEY_BYTES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_entry_value (o_entry_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_table_reply apply_table_op(t_op op, skvt_pkg::t_key key_in,
                                                    skvt_pkg::t_val val);
        t_table_reply   r;
        skvt_pkg::t_key key;
        int             pos;
        int             i;
        logic           hit;
        r   = '0;
        key = key_in & KEY_MASK;
        pos = 0;
        hit = 1'b0;
        if (op == skvt_pkg::OP_CLEAR) begin
            tbl_count = 0;
        end else begin
            while (pos < tbl_count && tbl_key[pos] < key) pos++;
            hit = (pos < tbl_count) && (tbl_key[pos] == key);
            if (op == skvt_pkg::OP_GET || op == skvt_pkg::OP_INSERT) begin
                if (hit) begin
                    if (op == skvt_pkg::OP_INSERT) tbl_val[pos] = val;
                    r.value = tbl_val[pos];
                end else if (tbl_count < DEPTH) begin
                    for (i = tbl_count; i > pos; i--) begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_val[i] = tbl_val[i-1];
                    end
                    tbl_key[pos] = key;
                    tbl_val[pos] = (op == skvt_pkg::OP_INSERT) ? val : '0;
                    tbl_count++;
                    r.value = tbl_val[pos];
                end else begin
                    r.status = 1'b1;
                end
            end else if (op == skvt_pkg::OP_ERASE) begin
                if (hit) begin
                    for (i = pos; i + 1 < tbl_count; i++) begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_val[i] = tbl_val[i+1];
                    end
                    tbl_count--;
                end
            end else if (hit) begin
                r.value = tbl_val[pos];
            end
        end
        r.found = hit;
        r.count = CW'(tbl_count);
        return r;
    endfunction

    function automatic skvt_pkg::t_key pack_name(string s);
        skvt_pkg::t_key k;
        k = '0;
        for (int i = 0; i < s.len() && i < 8; i++) k[63-8*i -: 8] = s[i];
        return k;
    endfunction

    function automatic skvt_pkg::t_key random_name();
        skvt_pkg::t_key k;
        int             len;
        k   = '0;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) k[63-8*i -: 8] = 8'("a") + 8'($urandom_range(0, 25));
        return k;
    endfunction

    task automatic send_beat(t_op op, skvt_pkg::t_key key, skvt_pkg::t_val val);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
            if (idle_on) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        start       <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        i_value     <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        reply_q.push_back(apply_table_op(op, key, val));
    endtask

    task automatic test_directed();
        skvt_pkg::t_key alpha;
        skvt_pkg::t_key mid;
        alpha = pack_name("alpha");
        mid   = pack_name("m");
        send_beat(skvt_pkg::OP_FIND,   alpha, 32'h1234_5678);
        send_beat(skvt_pkg::OP_ERASE,  alpha, '0);
        send_beat(skvt_pkg::OP_GET,    alpha, 32'hDEAD_BEEF);
        send_beat(skvt_pkg::OP_INSERT, alpha, 32'hFFFF_FFFF);
        send_beat(skvt_pkg::OP_INSERT, '0, '0);
        send_beat(skvt_pkg::OP_INSERT, '1, 32'hA5A5_5A5A);
        send_beat(skvt_pkg::OP_INSERT, mid, 32'd1);
        send_beat(skvt_pkg::OP_FIND,   '0, '0);
        send_beat(skvt_pkg::OP_FIND,   '1, '0);
        send_beat(skvt_pkg::OP_GET,    '1, 32'h0000_0001);
        send_beat(skvt_pkg::OP_GET,    mid, '1);
        send_beat(OP_UNUSED_LO,        alpha, '1);
        send_beat(OP_UNUSED_MID,       mid, '1);
        send_beat(OP_UNUSED_HI,        pack_name("zz"), '1);
        send_beat(skvt_pkg::OP_ERASE,  mid, '0);
        send_beat(skvt_pkg::OP_ERASE,  pack_name("nope"), '0);
        send_beat(skvt_pkg::OP_FIND,   mid, '0);
        send_beat(skvt_pkg::OP_ERASE,  '0, '0);
        send_beat(skvt_pkg::OP_ERASE,  '1, '0);
        send_beat(skvt_pkg::OP_CLEAR,  alpha, '1);
        send_beat(skvt_pkg::OP_FIND,   alpha, '0);
        send_beat(skvt_pkg::OP_CLEAR,  '0, '0);
    endtask

    task automatic test_full_table();
        skvt_pkg::t_key keys [DEPTH];
        for (int i = 0; i < DEPTH; i++) keys[i] = {$urandom, 26'($urandom), 6'(i)};
        send_beat(skvt_pkg::OP_CLEAR, '0, '0);
        for (int i = DEPTH - 1; i >= 0; i--) send_beat(skvt_pkg::OP_INSERT, keys[i], $urandom);
        send_beat(skvt_pkg::OP_INSERT, {$urandom, 32'hFFFF_FFC0}, $urandom);
        send_beat(skvt_pkg::OP_GET,    '1, $urandom);
        send_beat(skvt_pkg::OP_FIND,   '1, '0);
        send_beat(skvt_pkg::OP_INSERT, keys[5], '1);
        send_beat(skvt_pkg::OP_GET,    keys[DEPTH-1], '0);
        send_beat(skvt_pkg::OP_ERASE,  keys[0], '0);
        send_beat(skvt_pkg::OP_GET,    '0, '1);
        send_beat(skvt_pkg::OP_INSERT, random_name(), $urandom);
        send_beat(skvt_pkg::OP_CLEAR,  '0, '0);
    endtask

    task automatic test_random_mix();
        int             pool_sizes [8] = '{4, 12, 40, 70, 100, 8, 70, 150};
        int             erase_pcts [8] = '{20, 25, 10, 5, 15, 40, 30, 10};
        skvt_pkg::t_key pool [$];
        skvt_pkg::t_key key;
        skvt_pkg::t_val val;
        t_op            op;
        int             r;
        for (int ph = 0; ph < 8; ph++) begin
            idle_on = (ph % 3) != 2;
            pool.delete();
            for (int i = 0; i < pool_sizes[ph]; i++) begin
                case ($urandom_range(0, 3))
                    0: pool.push_back(random_name());
                    1: pool.push_back({$urandom, $urandom});
                    2: pool.push_back(skvt_pkg::t_key'($urandom_range(0, 255)));
                    default: pool.push_back(($urandom_range(0, 1) == 1) ?
                                            ~skvt_pkg::t_key'(i) : skvt_pkg::t_key'(i));
                endcase
            end
            for (int n = 0; n < 200; n++) begin
                r = $urandom_range(0, 99);
                if (r < 2) op = t_op'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                else if (r < 3) op = skvt_pkg::OP_CLEAR;
                else if (r < 3 + erase_pcts[ph]) op = skvt_pkg::OP_ERASE;
                else case ($urandom_range(0, 2))
                    0: op = skvt_pkg::OP_FIND;
                    1: op = skvt_pkg::OP_GET;
                    default: op = skvt_pkg::OP_INSERT;
                endcase
                key = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                                   : pool[$urandom_range(0, pool.size() - 1)];
                case ($urandom_range(0, 5))
                    0: val = '0;
                    1: val = '1;
                    default: val = $urandom;
                endcase
                send_beat(op, key, val);
            end
        end
    endtask

    always @(posedge i_clk) begin : check_beat
        t_table_reply exp_r;
        if (i_rst_n && o_done) begin
            if (reply_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                exp_r = reply_q.pop_front();
                if (o_found !== exp_r.found) begin
                    $error("found: expected %0d, got %0d", exp_r.found, o_found);
                    errors++;
                end
                if (o_entry_value !== exp_r.value) begin
                    $error("entry_value: expected %h, got %h", exp_r.value, o_entry_value);
                    errors++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    errors++;
                end
                if (o_entry_count !== exp_r.count) begin
                    $error("entry_count: expected %0d, got %0d", exp_r.count, o_entry_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_random_mix();
        start <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
rtl/skvt_pkg.sv
rtl/skvt_cell.sv
rtl/sorted_key_value_table_top.sv
rtl/skvt_check.sv
sim/testbench.sv
